// ===== rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // pattern bytes held by the two pattern registers
    localparam int REG_PATTERN_BYTES   = 16;
    localparam int PATTERN_MAX_DEFAULT = 16;

    localparam int LEN_W   = 5;
    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_REGION_BASE    = 3'd4,
        REG_REPORT_ALL     = 3'd5
    } t_reg_idx;

    // live configuration; active_len is already clamped into range
    typedef struct packed {
        logic [8*REG_PATTERN_BYTES-1:0] pattern;
        logic [REG_PATTERN_BYTES-1:0]   care;
        logic [LEN_W-1:0]               active_len;
        logic [ADDR_W-1:0]              region_base;
        logic                           report_all;
    } t_scan_cfg;

    // per-beat control seen by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== rtl/mbps_if.sv =====
// ----------------------------------------------------------------------------
// mbps channel interfaces
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        is_match;
    logic [63:0] match_address;
    logic        region_done;
    logic [31:0] match_total;

    modport source (output valid, output is_match, output match_address,
                    output region_done, output match_total, input ready);
    modport sink   (input valid, input is_match, input match_address,
                    input region_done, input match_total, output ready);
endinterface

interface mbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mbps_regs.sv =====
// ----------------------------------------------------------------------------
// mbps_regs
// Configuration register file; clamps the pattern length on write.
// ----------------------------------------------------------------------------
module mbps_regs
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbps_cfg_if.sink    i_cfg,
    output t_scan_cfg   o_cfg
);

    localparam int LEN_MAX = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX
                                                                : REG_PATTERN_BYTES;
    localparam logic [LEN_W-1:0] LEN_MAX_V = LEN_W'(LEN_MAX);

    logic [63:0]                 r_pat_lo;
    logic [63:0]                 r_pat_hi;
    logic [REG_PATTERN_BYTES-1:0] r_care;
    logic [LEN_W-1:0]            r_len;
    logic [ADDR_W-1:0]           r_base;
    logic                        r_all;
    logic [LEN_W-1:0]            n_len;
    logic                        w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    always_comb begin
        n_len = i_cfg.data[LEN_W-1:0];
        if (n_len == '0) begin
            n_len = LEN_W'(1);
        end else if (n_len > LEN_MAX_V) begin
            n_len = LEN_MAX_V;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_care   <= '1;
            r_len    <= LEN_W'(1);
            r_base   <= '0;
            r_all    <= 1'b0;
        end else if (w_wr) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_PATTERN_LOW:    r_pat_lo <= i_cfg.data;
                REG_PATTERN_HIGH:   r_pat_hi <= i_cfg.data;
                REG_CARE_MASK:      r_care   <= i_cfg.data[REG_PATTERN_BYTES-1:0];
                REG_PATTERN_LENGTH: r_len    <= n_len;
                REG_REGION_BASE:    r_base   <= i_cfg.data;
                REG_REPORT_ALL:     r_all    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg.pattern     = {r_pat_hi, r_pat_lo};
    assign o_cfg.care        = r_care;
    assign o_cfg.active_len  = r_len;
    assign o_cfg.region_base = r_base;
    assign o_cfg.report_all  = r_all;

endmodule

// ===== rtl/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it on, checks it against the
// pattern byte that lands on this position for the active length.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_scan_cfg  i_cfg,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte,
    output logic       o_ok
);

    localparam logic [LEN_W-1:0] IDX = LEN_W'(CELL_IDX);

    logic [7:0]       r_byte;
    logic [LEN_W-1:0] w_pidx;
    logic [7:0]       w_pat;
    logic             w_care;
    logic             w_active;

    // window position j faces pattern byte len-1-j
    assign w_pidx   = i_cfg.active_len - LEN_W'(1) - IDX;
    assign w_active = IDX < i_cfg.active_len;
    assign w_pat    = i_cfg.pattern[8*w_pidx[3:0] +: 8];
    assign w_care   = i_cfg.care[w_pidx[3:0]];

    // compare against the byte that enters this cell on the current beat
    assign o_ok = !w_active || !w_care || (i_byte == w_pat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_ctl.clear ? 8'd0 : i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== rtl/masked_byte_pattern_scanner_top.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Wildcard byte signature scan over a streamed memory region.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (index, data), always ready; write only while
//            the scanner is idle. Index 0/1 pattern bytes, 2 care mask,
//            3 pattern length, 4 region base, 5 report-all mode.
//   i_in   : one region byte per beat, last_byte set on the final byte.
//   o_out  : one beat per reported match and one for the final byte; a match
//            on the final byte gives a single beat with both flags set.
// Throughput is one byte per cycle unless a held result is stalled; each
// result beat appears in the cycle after its input beat. The window is a
// row of byte cells shifted on every accepted beat, each comparing the byte
// it takes in against its pattern byte, and the match is formed from those
// compares and the counters in the same cycle into the output register.
// When the receiver stalls with a result held, i_in.ready drops until the
// result is taken; bytes that cause no result pass freely otherwise.
// Reset clears the window, counters and output valid flag and loads the
// register defaults (care mask all ones, length 1, first-match mode).
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbps_cfg_if.sink    i_cfg,
    mbps_in_if.sink     i_in,
    mbps_out_if.source  o_out
);

    localparam int WIN_DEPTH = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX
                                                                  : REG_PATTERN_BYTES;

    t_scan_cfg             w_cfg;
    t_cell_ctl             w_ctl;
    logic [7:0]            w_chain [WIN_DEPTH];
    logic [WIN_DEPTH-1:0]  w_ok;
    logic                  w_acc;
    logic                  w_hit;

    logic [COUNT_W-1:0]    r_seen;
    logic [COUNT_W-1:0]    r_matches;
    logic                  r_found;
    logic [COUNT_W-1:0]    n_seen;
    logic [COUNT_W-1:0]    n_matches;
    logic [COUNT_W-1:0]    w_off;

    logic                  r_out_valid;
    logic                  r_is_match;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_done;
    logic [COUNT_W-1:0]    r_total;

    mbps_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_ctl.shift = w_acc;
    assign w_ctl.clear = i_in.last_byte;

    assign w_chain[0] = i_in.data_byte;

    for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
        if (j < WIN_DEPTH - 1) begin : g_mid
            mbps_cell #(
                .CELL_IDX (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_cfg   (w_cfg),
                .i_byte  (w_chain[j]),
                .o_byte  (w_chain[j+1]),
                .o_ok    (w_ok[j])
            );
        end else begin : g_end
            mbps_cell #(
                .CELL_IDX (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_cfg   (w_cfg),
                .i_byte  (w_chain[j]),
                .o_byte  (),
                .o_ok    (w_ok[j])
            );
        end
    end

    // saturating counts after this beat
    assign n_seen = (r_seen == '1) ? r_seen : r_seen + COUNT_W'(1);
    assign w_off  = n_seen - COUNT_W'(w_cfg.active_len);

    assign w_hit = (n_seen >= COUNT_W'(w_cfg.active_len)) && (&w_ok) &&
                   (w_cfg.report_all || !r_found);

    assign n_matches = (w_hit && r_matches != '1) ? r_matches + COUNT_W'(1)
                                                  : r_matches;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_matches <= '0;
            r_found   <= 1'b0;
        end else if (w_acc) begin
            if (i_in.last_byte) begin
                r_seen    <= '0;
                r_matches <= '0;
                r_found   <= 1'b0;
            end else begin
                r_seen    <= n_seen;
                r_matches <= n_matches;
                r_found   <= r_found || w_hit;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && (w_hit || i_in.last_byte)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_hit || i_in.last_byte)) begin
            r_is_match <= w_hit;
            r_addr     <= w_hit ? w_cfg.region_base + {32'd0, w_off} : '0;
            r_done     <= i_in.last_byte;
            r_total    <= n_matches;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.is_match      = r_is_match;
    assign o_out.match_address = r_addr;
    assign o_out.region_done   = r_done;
    assign o_out.match_total   = r_total;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the masked byte pattern scanner. Streams directed
// and random regions, predicts every result beat in the bench and compares
// each beat field by field, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import mbps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WIN_DEPTH   = PATTERN_MAX_DEFAULT;
    localparam int LEN_CAP     = (REG_PATTERN_BYTES < PATTERN_MAX_DEFAULT) ?
                                 REG_PATTERN_BYTES : PATTERN_MAX_DEFAULT;
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic               is_match;
        logic [ADDR_W-1:0]  match_address;
        logic               region_done;
        logic [COUNT_W-1:0] match_total;
    } t_scan_report;

    logic i_clk;
    logic i_rst_n;

    mbps_cfg_if cfg_bus ();
    mbps_in_if  in_bus ();
    mbps_out_if out_bus ();

    masked_byte_pattern_scanner_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // register image
    logic [8*REG_PATTERN_BYTES-1:0] cfg_pattern = '0;
    logic [15:0]                    cfg_care    = 16'hFFFF;
    logic [LEN_W-1:0]               cfg_len     = 5'd1;
    logic [ADDR_W-1:0]              cfg_base    = '0;
    logic                           cfg_all     = 1'b0;

    // scan state
    logic [7:0]         win_bytes [WIN_DEPTH];
    logic [COUNT_W-1:0] bytes_seen      = '0;
    logic [COUNT_W-1:0] hits_in_region  = '0;
    logic               found_in_region = 1'b0;

    t_scan_report scan_reports [$];

    int err_count     = 0;
    int bytes_sent    = 0;
    int beats_checked = 0;
    int match_beats   = 0;
    int regions_done  = 0;
    int cycle_count   = 0;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (win_bytes[k]) win_bytes[k] = 8'h00;
    end

    function automatic int eff_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > LEN_CAP) return LEN_CAP;
        return int'(cfg_len);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_LOW:    cfg_pattern[63:0]   = data;
            REG_PATTERN_HIGH:   cfg_pattern[127:64] = data;
            REG_CARE_MASK:      cfg_care = data[15:0];
            REG_PATTERN_LENGTH: cfg_len  = data[LEN_W-1:0];
            REG_REGION_BASE:    cfg_base = data;
            REG_REPORT_ALL:     cfg_all  = data[0];
            default: ;
        endcase
    endfunction

    // shift the window, compare under the care mask, queue the beat if any
    function automatic void compute_scan_result(logic [7:0] b, logic is_last);
        int n;
        logic ok;
        logic hit;
        t_scan_report r;
        n = eff_len();
        for (int k = WIN_DEPTH - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
        win_bytes[0] = b;
        if (bytes_seen != '1) bytes_seen++;
        ok = 1'b1;
        for (int i = 0; i < n; i++)
            if (cfg_care[i] && win_bytes[n-1-i] != cfg_pattern[8*i +: 8]) ok = 1'b0;
        hit = (bytes_seen >= n) && ok && (cfg_all || !found_in_region);
        r = '0;
        if (hit) begin
            r.is_match      = 1'b1;
            r.match_address = cfg_base + 64'(bytes_seen - 32'(n));
            found_in_region = 1'b1;
            if (hits_in_region != '1) hits_in_region++;
        end
        if (hit || is_last) begin
            r.region_done = is_last;
            r.match_total = hits_in_region;
            scan_reports.insert(scan_reports.size(), r);
        end
        if (is_last) begin
            foreach (win_bytes[k]) win_bytes[k] = 8'h00;
            bytes_seen      = '0;
            hits_in_region  = '0;
            found_in_region = 1'b0;
        end
    endfunction

    function automatic void check_result();
        t_scan_report want;
        if (scan_reports.size() == 0) begin
            $error("result beat with nothing expected: match=%0b addr=%h done=%0b total=%0d",
                   out_bus.is_match, out_bus.match_address, out_bus.region_done,
                   out_bus.match_total);
            err_count++;
            return;
        end
        want = scan_reports.pop_front();
        beats_checked++;
        if (want.is_match) match_beats++;
        if (want.region_done) regions_done++;
        if (out_bus.is_match !== want.is_match) begin
            $error("is_match: expected %0b, got %0b", want.is_match, out_bus.is_match);
            err_count++;
        end
        if (out_bus.match_address !== want.match_address) begin
            $error("match_address: expected %h, got %h",
                   want.match_address, out_bus.match_address);
            err_count++;
        end
        if (out_bus.region_done !== want.region_done) begin
            $error("region_done: expected %0b, got %0b", want.region_done, out_bus.region_done);
            err_count++;
        end
        if (out_bus.match_total !== want.match_total) begin
            $error("match_total: expected %0d, got %0d", want.match_total, out_bus.match_total);
            err_count++;
        end
    endfunction

    // monitor: result beats first, then register writes, then input beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_bus.valid && out_bus.ready) check_result();
            if (cfg_bus.valid && cfg_bus.ready) apply_reg(cfg_bus.index, cfg_bus.data);
            if (in_bus.valid && in_bus.ready)
                compute_scan_result(in_bus.data_byte, in_bus.last_byte);
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= !(stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat,
    // with valid still high
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            in_bus.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.last_byte <= is_last;
        do @(posedge i_clk); while (!in_bus.ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_bus.valid <= 1'b0;
        while (scan_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic [63:0] pat_lo, input logic [63:0] pat_hi,
                             input logic [63:0] care, input logic [63:0] len,
                             input logic [63:0] base, input logic [63:0] all);
        wait_idle();
        write_reg(REG_PATTERN_LOW, pat_lo);
        write_reg(REG_PATTERN_HIGH, pat_hi);
        write_reg(REG_CARE_MASK, care);
        write_reg(REG_PATTERN_LENGTH, len);
        write_reg(REG_REGION_BASE, base);
        write_reg(REG_REPORT_ALL, all);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        // pattern 00, length 1, first match only
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_wildcard_wrap();
        logic [127:0] pat;
        pat = {64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00};
        // length 31 clamps to 16, byte 5 wildcard, address wraps past the top
        configure(pat[63:0], pat[127:64], 64'hFFDF, 64'd31, '1, 64'd1);
        send_byte(8'h5A, 1'b0);
        for (int i = 0; i < 16; i++)
            send_byte((i == 5) ? 8'h3C : pat[8*i +: 8], i == 15);
    endtask

    task automatic test_short_region();
        // region shorter than the 16-byte pattern
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_length_clamp();
        // length 0 acts as 1; care bits above the length are ignored
        configure(64'hCDAB, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF, 64'd0, 64'h1000, 64'd1);
        write_reg(REG_UNMAPPED, '1);
        cfg_bus.valid <= 1'b0;
        send_byte(8'hAB, 1'b0);
        // change the pattern in the middle of the region
        wait_idle();
        write_reg(REG_PATTERN_LOW, 64'h12);
        cfg_bus.valid <= 1'b0;
        send_byte(8'h12, 1'b0);
        send_byte(8'h12, 1'b1);
    endtask

    task automatic load_random_config();
        logic [4:0]  len;
        logic [15:0] care;
        logic [63:0] base;
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [63:0] noise;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = 5'($urandom_range(1, 4));
            6, 7:             len = 5'($urandom_range(5, 16));
            8:                len = 5'd16;
            default:          len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
        endcase
        care   = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        base   = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) base = '1 - 64'($urandom_range(0, 64));
        pat_lo = {$urandom, $urandom};
        pat_hi = {$urandom, $urandom};
        // repeated byte gives overlapping matches
        if ($urandom_range(0, 3) == 0) begin
            pat_lo = {8{8'($urandom)}};
            pat_hi = pat_lo;
        end
        noise  = {$urandom, $urandom};
        configure(pat_lo, pat_hi, {noise[63:16], care}, {noise[63:5], len}, base,
                  {noise[63:1], 1'($urandom_range(0, 1))});
    endtask

    // region built from planted pattern copies, pattern bytes and noise
    task automatic send_random_region(input logic terminate);
        logic [7:0] region_q [$];
        int region_len;
        int n;
        int pick;
        n = eff_len();
        region_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250) :
                                                     $urandom_range(1, 40);
        while (region_q.size() < region_len) begin
            if ($urandom_range(0, 99) < 20 && region_q.size() + n <= region_len) begin
                for (int i = 0; i < n; i++)
                    region_q.insert(region_q.size(),
                                    cfg_care[i] ? cfg_pattern[8*i +: 8] : 8'($urandom));
            end else if ($urandom_range(0, 1)) begin
                pick = $urandom_range(0, n - 1);
                region_q.insert(region_q.size(), cfg_pattern[8*pick +: 8]);
            end else begin
                region_q.insert(region_q.size(), 8'($urandom));
            end
        end
        foreach (region_q[j])
            send_byte(region_q[j], terminate && (j == region_q.size() - 1));
    endtask

    task automatic run_random_phase(input int idle, input int stall, input int target);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = bytes_sent;
        while (bytes_sent - start < target) begin
            load_random_config();
            // an unterminated region carries over into the next setting
            repeat ($urandom_range(1, 4)) send_random_region($urandom_range(0, 4) != 0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 250);
        run_random_phase(83, 0, 250);
        run_random_phase(0, 83, 250);
        run_random_phase(25, 25, 250);
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        // every byte matches, so every beat yields a result
        configure('1, '1, 64'h0, 64'd1, 64'h8000_0000_0000_0000, 64'd1);
        hold_req = 300;
        for (int i = 0; i < 80; i++) send_byte(8'($urandom), i == 79);
        wait_idle();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        in_bus.valid     = 1'b0;
        in_bus.data_byte = '0;
        in_bus.last_byte = 1'b0;
        out_bus.ready    = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_wildcard_wrap();
        test_short_region();
        test_length_clamp();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (scan_reports.size() != 0) begin
            $error("%0d result beats never arrived", scan_reports.size());
            err_count += scan_reports.size();
        end
        $display("scanned %0d bytes in %0d regions over %0d cycles", bytes_sent, regions_done,
                 cycle_count);
        $display("checked %0d result beats, %0d carrying a match, %0d errors", beats_checked,
                 match_beats, err_count);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
